// ----- hdl/kos_pkg.sv -----
// Shared types and constants for the k-th largest order-statistic set.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package kos_pkg;

  // Store geometry.
  // CNT_W is fixed by the count field and must be able to hold CAPACITY.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int KEY_W    = 32;
  localparam int RANK_W   = 7;

  // Read-out tree: cells are ORed in groups, then the groups are ORed.
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  // Operation codes
  localparam logic [1:0] ACT_QUERY  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANK    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // Request beat
  typedef struct packed {
    logic [1:0]              action;
    logic signed [KEY_W-1:0] key;
    logic [RANK_W-1:0]       rank;
  } op_t;

  // Response beat
  typedef struct packed {
    logic signed [KEY_W-1:0] kth_value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        stored_count;
  } res_t;

  // Control that is broadcast to every cell
  typedef struct packed {
    logic                    ins;     // insert this cycle
    logic                    rem;     // remove this cycle (key known present)
    logic signed [KEY_W-1:0] key;
    logic [CNT_W-1:0]        count;
    logic                    q_hit;   // query read-out enabled
    logic [IDX_W-1:0]        target;  // cell index read out by a query
  } cell_ctl_t;

endpackage

// ----- hdl/kth_largest_order_statistic_set.sv -----
// Sorted multiset of up to 64 signed 32-bit keys with insert, remove-one-copy and
// k-th largest query; each request beat gives one response beat with value, status
// and count. An operation proceeds from request to offered response: the accept
// cycle updates the whole cell chain in parallel, states GATHER and FINISH run the
// registered OR tree that reads out a queried cell, and the response register then
// holds the beat until it is taken. One request is handled at a time; a new request
// is taken in the cycle after the response beat leaves. Nothing needs clearing after
// reset beyond the fill count. Depends on kos_pkg, kos_cell and kos_reduce.
`timescale 1ns / 1ps

module kth_largest_order_statistic_set (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  output logic            op_ready,
  input  kos_pkg::op_t    op,
  output logic            res_valid,
  input  logic            res_ready,
  output kos_pkg::res_t   res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_GATHER = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0]                       state;
  logic [1:0]                       state_next;
  logic [kos_pkg::CNT_W-1:0]        count;
  logic [kos_pkg::CNT_W-1:0]        count_next;
  logic [1:0]                       pend_status;
  logic [1:0]                       status_next;
  logic                             q_hit;
  logic                             q_hit_next;
  logic [kos_pkg::IDX_W-1:0]        target;
  logic [kos_pkg::CNT_W-1:0]        diff;
  logic                             accept;
  logic                             found;
  logic                             do_ins;
  logic                             do_rem;
  kos_pkg::cell_ctl_t               ctl;
  logic signed [kos_pkg::KEY_W-1:0] cell_key  [kos_pkg::CAPACITY];
  logic signed [kos_pkg::KEY_W-1:0] cell_pick [kos_pkg::CAPACITY];
  logic [kos_pkg::CAPACITY-1:0]     cell_gt;
  logic [kos_pkg::CAPACITY-1:0]     cell_eq;
  logic signed [kos_pkg::KEY_W-1:0] tree_value;

  assign op_ready  = state == S_IDLE;
  assign res_valid = state == S_OUT;
  assign accept    = op_valid && op_ready;
  assign found     = |cell_eq;
  assign diff      = count - op.rank;

  // Decode the request beat
  always_comb begin
    status_next = kos_pkg::ST_OK;
    count_next  = count;
    q_hit_next  = 1'b0;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    unique case (op.action)
      kos_pkg::ACT_QUERY: begin
        if (op.rank == '0 || op.rank > count) begin
          status_next = kos_pkg::ST_RANK;
        end else begin
          q_hit_next = 1'b1;
        end
      end
      kos_pkg::ACT_INSERT: begin
        if (count >= kos_pkg::CNT_W'(kos_pkg::CAPACITY)) begin
          status_next = kos_pkg::ST_FULL;
        end else begin
          do_ins     = accept;
          count_next = count + kos_pkg::CNT_W'(1);
        end
      end
      kos_pkg::ACT_REMOVE: begin
        if (!found) begin
          status_next = kos_pkg::ST_MISSING;
        end else begin
          do_rem     = accept;
          count_next = count - kos_pkg::CNT_W'(1);
        end
      end
      default: begin
        status_next = kos_pkg::ST_OK;
      end
    endcase
  end

  // Broadcast control to the chain
  always_comb begin
    ctl.ins    = do_ins;
    ctl.rem    = do_rem;
    ctl.key    = op.key;
    ctl.count  = count;
    ctl.q_hit  = q_hit;
    ctl.target = target;
  end

  // Cell chain
  for (genvar i = 0; i < kos_pkg::CAPACITY; i++) begin : g_cell
    logic                             lgt;
    logic signed [kos_pkg::KEY_W-1:0] lkey;
    logic signed [kos_pkg::KEY_W-1:0] rkey;

    if (i == 0) begin : g_first
      assign lgt  = 1'b0;
      assign lkey = '0;
    end else begin : g_mid
      assign lgt  = cell_gt[i-1];
      assign lkey = cell_key[i-1];
    end
    if (i == kos_pkg::CAPACITY - 1) begin : g_last
      assign rkey = '0;
    end else begin : g_inner
      assign rkey = cell_key[i+1];
    end

    kos_cell u_cell (
      .clk       (clk),
      .idx       (kos_pkg::IDX_W'(i)),
      .ctl       (ctl),
      .left_gt   (lgt),
      .left_key  (lkey),
      .right_key (rkey),
      .key       (cell_key[i]),
      .gt        (cell_gt[i]),
      .eq        (cell_eq[i]),
      .pick      (cell_pick[i])
    );
  end

  kos_reduce u_reduce (
    .clk   (clk),
    .load  (state == S_GATHER),
    .pick  (cell_pick),
    .value (tree_value)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_GATHER;
      S_GATHER: state_next = S_FINISH;
      S_FINISH: state_next = S_OUT;
      S_OUT:    if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      q_hit <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
        q_hit <= q_hit_next;
      end else if (state == S_FINISH) begin
        q_hit <= 1'b0;
      end
    end
  end

  // Beat payload held for the response
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      target      <= diff[kos_pkg::IDX_W-1:0];
    end
    if (state == S_FINISH) begin
      res.kth_value    <= tree_value;
      res.status       <= pend_status;
      res.stored_count <= count;
    end
  end

endmodule

// ----- hdl/kos_cell.sv -----
// One slot of the sorted key chain. Holds a single key and shifts it towards
// either neighbour on insert or remove. Depends on kos_pkg.
`timescale 1ns / 1ps

module kos_cell (
  input  logic                             clk,
  input  logic [kos_pkg::IDX_W-1:0]        idx,
  input  kos_pkg::cell_ctl_t               ctl,
  input  logic                             left_gt,
  input  logic signed [kos_pkg::KEY_W-1:0] left_key,
  input  logic signed [kos_pkg::KEY_W-1:0] right_key,
  output logic signed [kos_pkg::KEY_W-1:0] key,
  output logic                             gt,
  output logic                             eq,
  output logic signed [kos_pkg::KEY_W-1:0] pick
);

  logic [kos_pkg::CNT_W-1:0]        idx_ext;
  logic                             valid;
  logic                             at_end;
  logic                             ge;
  logic signed [kos_pkg::KEY_W-1:0] key_next;

  // Occupancy follows from the position in the chain and the fill count
  assign idx_ext = {{(kos_pkg::CNT_W - kos_pkg::IDX_W){1'b0}}, idx};
  assign valid   = idx_ext < ctl.count;
  assign at_end  = idx_ext == ctl.count;

  // Compare the held key against the key on the beat
  assign gt = valid && (key > ctl.key);
  assign eq = valid && (key == ctl.key);
  assign ge = valid && (key >= ctl.key);

  // Query read-out: only the addressed cell drives a non-zero value
  assign pick = (ctl.q_hit && (idx == ctl.target)) ? key : '0;

  // Insert: larger keys move up one slot, the new key lands after equal keys.
  // Remove: from the first matching key onwards every occupied slot takes its right neighbour.
  always_comb begin
    key_next = key;
    if (ctl.ins && (valid || at_end)) begin
      if (left_gt) begin
        key_next = left_key;
      end else if (gt || at_end) begin
        key_next = ctl.key;
      end
    end else if (ctl.rem && ge) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

// ----- hdl/kos_reduce.sv -----
// Registered OR tree that collects the single non-zero read-out of the cell chain.
// Depends on kos_pkg.
`timescale 1ns / 1ps

module kos_reduce (
  input  logic                             clk,
  input  logic                             load,
  input  logic signed [kos_pkg::KEY_W-1:0] pick [kos_pkg::CAPACITY],
  output logic signed [kos_pkg::KEY_W-1:0] value
);

  logic signed [kos_pkg::KEY_W-1:0] grp      [kos_pkg::NGRP];
  logic signed [kos_pkg::KEY_W-1:0] grp_next [kos_pkg::NGRP];

  // First level: OR each group of cells
  always_comb begin
    for (int g = 0; g < kos_pkg::NGRP; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < kos_pkg::GRP; j++) begin
        if (g * kos_pkg::GRP + j < kos_pkg::CAPACITY) begin
          grp_next[g] = grp_next[g] | pick[g * kos_pkg::GRP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < kos_pkg::NGRP; g++) begin
        grp[g] <= grp_next[g];
      end
    end
  end

  // Second level: OR the group registers
  always_comb begin
    value = '0;
    for (int g = 0; g < kos_pkg::NGRP; g++) begin
      value = value | grp[g];
    end
  end

endmodule
